/* design/tcce_pkg.sv */
// Shared types and constants for the text console cell engine.
`default_nettype none

package tcce_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int COLOR_W    = 4;
  localparam int POS_COL_W  = 7;
  localparam int POS_ROW_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int COLS_CFG_W = 8;
  localparam int ROWS_CFG_W = 7;
  localparam int CMP_W      = 16;

  // Tab stops every 8 columns
  localparam int TAB_STEP  = 8;
  localparam int TAB_LOW_W = 3;

  // Register reset values
  localparam int COLS_RST = 80;
  localparam int ROWS_RST = 25;
  localparam logic [COLOR_W-1:0] CUR_FG_RST   = 4'd7;
  localparam logic [COLOR_W-1:0] CUR_BG_RST   = 4'd0;
  localparam logic [COLOR_W-1:0] BLANK_FG_RST = 4'd7;
  localparam logic [COLOR_W-1:0] BLANK_BG_RST = 4'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CUR_FG   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUR_BG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_FG = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_BG = 3'd5;

  // Character codes
  localparam logic [CHAR_W-1:0] CHR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHR_QMARK = 8'h3F;
  localparam logic [CHAR_W-1:0] PRINT_LO  = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI  = 8'h7E;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
  } cell_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_TAB,
    ST_SCROLL,
    ST_DRAIN,
    ST_BLANK,
    ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_EXEC,
    OP_TAB,
    OP_COPY,
    OP_BOTTOM,
    OP_BLANK
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    logic   rd_en;
    logic   rd_swp;
    dp_op_t op;
    logic   finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_last;
    logic swp_last;
    logic tab_last;
    logic go_tab;
    logic go_scroll;
    logic go_clear;
    logic single_row;
    logic slot_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* design/tcce_if.sv */
// Input and result channel interfaces of the text console cell engine.
`default_nettype none

interface tcce_in_if import tcce_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [CHAR_W-1:0]    char_code;
  logic [POS_COL_W-1:0] read_column;
  logic [POS_ROW_W-1:0] read_row;

  modport source (output valid, command, char_code, read_column, read_row, input ready);
  modport sink   (input valid, command, char_code, read_column, read_row, output ready);
endinterface

interface tcce_out_if import tcce_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CHAR_W-1:0]    cell_char;
  logic [COLOR_W-1:0]   cell_fg;
  logic [COLOR_W-1:0]   cell_bg;
  logic [POS_COL_W-1:0] cursor_column;
  logic [POS_ROW_W-1:0] cursor_line;
  logic                 did_scroll;
  logic                 outside_grid;

  modport source (output valid, cell_char, cell_fg, cell_bg, cursor_column, cursor_line,
                  did_scroll, outside_grid, input ready);
  modport sink   (input valid, cell_char, cell_fg, cell_bg, cursor_column, cursor_line,
                  did_scroll, outside_grid, output ready);
endinterface

`default_nettype wire

/* design/tcce_ctrl.sv */
// Controller state machine of the text console cell engine.
`default_nettype none

module tcce_ctrl import tcce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (sts.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        priority if (sts.go_clear) begin
          state_nxt = ST_BLANK;
        end else if (sts.go_scroll) begin
          state_nxt = sts.single_row ? ST_BLANK : ST_SCROLL;
        end else if (sts.go_tab) begin
          state_nxt = ST_TAB;
        end else begin
          state_nxt = sts.slot_free ? ST_IDLE : ST_RESULT;
        end
      end
      ST_TAB: begin
        if (sts.tab_last) state_nxt = sts.slot_free ? ST_IDLE : ST_RESULT;
      end
      ST_SCROLL: begin
        if (sts.swp_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_BLANK;
      end
      ST_BLANK: begin
        if (sts.swp_last) state_nxt = sts.slot_free ? ST_IDLE : ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.slot_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.rd_swp = 1'b0;
    cmd.op     = OP_NONE;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.op = OP_INIT;
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        cmd.rd_en  = in_valid;
      end
      ST_DECODE: begin
        cmd.op     = OP_EXEC;
        cmd.finish = !sts.go_clear && !sts.go_scroll && !sts.go_tab && sts.slot_free;
      end
      ST_TAB: begin
        cmd.op     = OP_TAB;
        cmd.finish = sts.tab_last && sts.slot_free;
      end
      ST_SCROLL: begin
        cmd.op     = OP_COPY;
        cmd.rd_en  = 1'b1;
        cmd.rd_swp = 1'b1;
      end
      ST_DRAIN: begin
        cmd.op = OP_BOTTOM;
      end
      ST_BLANK: begin
        cmd.op     = OP_BLANK;
        cmd.finish = sts.swp_last && sts.slot_free;
      end
      ST_RESULT: begin
        cmd.finish = sts.slot_free;
      end
    endcase
  end

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_DECODE)
    else $error("accepted item not decoded next cycle");

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> sts.slot_free)
    else $error("result loaded into occupied output register");

  a_drain_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> $past(state_r) == ST_SCROLL)
    else $error("drain entered without a copy sweep");

endmodule

`default_nettype wire

/* design/tcce_dp.sv */
// Datapath of the text console cell engine: registers, cursor, cell memory, result.
`default_nettype none

module tcce_dp import tcce_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [POS_COL_W-1:0]  in_read_column,
  input  logic [POS_ROW_W-1:0]  in_read_row,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_cell_char,
  output logic [COLOR_W-1:0]    out_cell_fg,
  output logic [COLOR_W-1:0]    out_cell_bg,
  output logic [POS_COL_W-1:0]  out_cursor_column,
  output logic [POS_ROW_W-1:0]  out_cursor_line,
  output logic                  out_did_scroll,
  output logic                  out_outside_grid
);

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = MAX_ROWS * (1 << CW);
  localparam int GW    = CW + 1;
  localparam int GRW   = RW + 1;
  localparam logic [GW-1:0]  COLS_MAX  = GW'(MAX_COLUMNS);
  localparam logic [GRW-1:0] ROWS_MAX  = GRW'(MAX_ROWS);
  localparam logic [GW-1:0]  COLS_INIT = (COLS_RST > MAX_COLUMNS) ? COLS_MAX : GW'(COLS_RST);
  localparam logic [GRW-1:0] ROWS_INIT = (ROWS_RST > MAX_ROWS) ? ROWS_MAX : GRW'(ROWS_RST);

  // Configuration, stored already clamped to 1..MAX
  logic [GW-1:0]      cols_r;
  logic [GRW-1:0]     rows_r;
  logic [COLOR_W-1:0] cur_fg_r, cur_bg_r, blank_fg_r, blank_bg_r;
  logic [GW-1:0]      cols_wr;
  logic [GRW-1:0]     rows_wr;

  // Item, cursor and sweep state
  cmd_t                 cmd_r;
  logic [CHAR_W-1:0]    code_r;
  logic [POS_COL_W-1:0] rcol_r;
  logic [POS_ROW_W-1:0] rrow_r;
  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [CW-1:0]        tab_end_r, tab_end_nxt;
  logic                 scroll_r, scroll_nxt;
  logic [RW-1:0]        swp_row_r, swp_row_nxt;
  logic [CW-1:0]        swp_col_r, swp_col_nxt;
  logic                 cp_v_r, cp_v_nxt;
  logic [AW-1:0]        cp_addr_r, cp_addr_nxt;

  // Cell memory
  cell_t         cell_mem [DEPTH];
  cell_t         rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic [AW-1:0] mem_raddr;

  // Result register
  logic                 out_valid_r;
  cell_t                out_cell_r;
  logic [POS_COL_W-1:0] out_col_r;
  logic [POS_ROW_W-1:0] out_row_r;
  logic                 out_scroll_r;
  logic                 out_outside_r;

  // Derived values
  logic [CW-1:0]  cols_m1;
  logic [RW-1:0]  rows_m1;
  logic [CW-1:0]  col_clamp;
  logic [RW-1:0]  row_clamp;
  logic [GW-1:0]  col_inc;
  logic           wrap;
  logic           at_bottom;
  logic [GW-1:0]  tab_sum;
  logic [GW-1:0]  tab_al;
  logic [CW-1:0]  tab_next;
  logic           is_put, is_cr, is_lf, is_bs, is_tab;
  logic           outside;
  logic [CHAR_W-1:0] put_char;
  cell_t          cur_space, blank_cell;

  always_comb begin
    if (cfg_wdata[COLS_CFG_W-1:0] == '0) begin
      cols_wr = GW'(1);
    end else if (CMP_W'(cfg_wdata[COLS_CFG_W-1:0]) > CMP_W'(MAX_COLUMNS)) begin
      cols_wr = COLS_MAX;
    end else begin
      cols_wr = GW'(cfg_wdata[COLS_CFG_W-1:0]);
    end
    if (cfg_wdata[ROWS_CFG_W-1:0] == '0) begin
      rows_wr = GRW'(1);
    end else if (CMP_W'(cfg_wdata[ROWS_CFG_W-1:0]) > CMP_W'(MAX_ROWS)) begin
      rows_wr = ROWS_MAX;
    end else begin
      rows_wr = GRW'(cfg_wdata[ROWS_CFG_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r     <= COLS_INIT;
      rows_r     <= ROWS_INIT;
      cur_fg_r   <= CUR_FG_RST;
      cur_bg_r   <= CUR_BG_RST;
      blank_fg_r <= BLANK_FG_RST;
      blank_bg_r <= BLANK_BG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS:  cols_r     <= cols_wr;
        CFG_ROWS:     rows_r     <= rows_wr;
        CFG_CUR_FG:   cur_fg_r   <= cfg_wdata[COLOR_W-1:0];
        CFG_CUR_BG:   cur_bg_r   <= cfg_wdata[COLOR_W-1:0];
        CFG_BLANK_FG: blank_fg_r <= cfg_wdata[COLOR_W-1:0];
        CFG_BLANK_BG: blank_bg_r <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_m1   = CW'(cols_r - GW'(1));
    rows_m1   = RW'(rows_r - GRW'(1));
    col_clamp = (GW'(col_r) >= cols_r) ? cols_m1 : col_r;
    row_clamp = (GRW'(row_r) >= rows_r) ? rows_m1 : row_r;
    col_inc   = GW'(col_r) + GW'(1);
    wrap      = col_inc >= cols_r;
    at_bottom = row_r == rows_m1;
    tab_sum   = GW'(col_r) + GW'(TAB_STEP);
    tab_al    = {tab_sum[GW-1:TAB_LOW_W], {TAB_LOW_W{1'b0}}};
    tab_next  = (tab_al >= cols_r) ? cols_m1 : CW'(tab_al);
    is_put    = cmd_r == CMD_PUT;
    is_cr     = code_r == CHR_CR;
    is_lf     = code_r == CHR_LF;
    is_bs     = code_r == CHR_BS;
    is_tab    = code_r == CHR_TAB;
    outside   = (CMP_W'(rcol_r) >= CMP_W'(cols_r)) || (CMP_W'(rrow_r) >= CMP_W'(rows_r));
    put_char  = (code_r < PRINT_LO || code_r > PRINT_HI) ? CHR_QMARK : code_r;
    cur_space  = cell_t'{ch: CHR_SPACE, fg: cur_fg_r, bg: cur_bg_r};
    blank_cell = cell_t'{ch: CHR_SPACE, fg: blank_fg_r, bg: blank_bg_r};
  end

  always_comb begin
    sts.init_last  = {swp_row_r, swp_col_r} == AW'(DEPTH - 1);
    sts.swp_last   = (swp_row_r == rows_m1) && (swp_col_r == cols_m1);
    sts.tab_last   = CW'(col_r + CW'(1)) == tab_end_r;
    sts.go_tab     = is_put && is_tab && (col_r < tab_next);
    sts.go_scroll  = is_put && at_bottom && (is_lf || (!is_cr && !is_bs && !is_tab && wrap));
    sts.go_clear   = cmd_r == CMD_CLEAR;
    sts.single_row = rows_r == GRW'(1);
    sts.slot_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    tab_end_nxt = tab_end_r;
    scroll_nxt  = scroll_r;
    swp_row_nxt = swp_row_r;
    swp_col_nxt = swp_col_r;
    cp_v_nxt    = 1'b0;
    cp_addr_nxt = cp_addr_r;
    mem_we      = 1'b0;
    mem_waddr   = {row_r, col_r};
    mem_wdata   = cur_space;

    // pending scroll copy owns the write port
    if (cp_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = cp_addr_r;
      mem_wdata = rd_data_r;
    end

    unique case (cmd.op)
      OP_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = {swp_row_r, swp_col_r};
        mem_wdata = '0;
        {swp_row_nxt, swp_col_nxt} = AW'({swp_row_r, swp_col_r} + AW'(1));
      end
      OP_EXEC: begin
        unique case (cmd_r)
          CMD_PUT: begin
            priority if (is_cr) begin
              col_nxt = '0;
            end else if (is_lf) begin
              col_nxt = '0;
              if (at_bottom) scroll_nxt = 1'b1;
              else row_nxt = RW'(row_r + RW'(1));
            end else if (is_bs) begin
              if (col_r != '0) begin
                col_nxt   = CW'(col_r - CW'(1));
                mem_we    = 1'b1;
                mem_waddr = {row_r, CW'(col_r - CW'(1))};
                mem_wdata = cur_space;
              end
            end else if (is_tab) begin
              tab_end_nxt = tab_next;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = {row_r, col_r};
              mem_wdata = cell_t'{ch: put_char, fg: cur_fg_r, bg: cur_bg_r};
              if (wrap) begin
                col_nxt = '0;
                if (at_bottom) scroll_nxt = 1'b1;
                else row_nxt = RW'(row_r + RW'(1));
              end else begin
                col_nxt = CW'(col_inc);
              end
            end
          end
          CMD_CLEAR: begin
            col_nxt = '0;
            row_nxt = '0;
          end
          CMD_READ, CMD_NOP: ;
        endcase
        // copy starts at source row 1; sweep is already at origin otherwise
        if (sts.go_scroll && !sts.single_row) swp_row_nxt = RW'(1);
      end
      OP_TAB: begin
        mem_we    = 1'b1;
        mem_waddr = {row_r, col_r};
        mem_wdata = cur_space;
        col_nxt   = CW'(col_r + CW'(1));
      end
      OP_COPY: begin
        cp_v_nxt    = 1'b1;
        cp_addr_nxt = {RW'(swp_row_r - RW'(1)), swp_col_r};
        if (swp_col_r == cols_m1) begin
          swp_col_nxt = '0;
          swp_row_nxt = RW'(swp_row_r + RW'(1));
        end else begin
          swp_col_nxt = CW'(swp_col_r + CW'(1));
        end
      end
      OP_BOTTOM: begin
        swp_row_nxt = rows_m1;
        swp_col_nxt = '0;
      end
      OP_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = {swp_row_r, swp_col_r};
        mem_wdata = blank_cell;
        if (swp_col_r == cols_m1) begin
          swp_col_nxt = '0;
          swp_row_nxt = RW'(swp_row_r + RW'(1));
        end else begin
          swp_col_nxt = CW'(swp_col_r + CW'(1));
        end
      end
      OP_NONE: ;
      default: ;
    endcase

    // new item: clamp cursor into the grid in use
    if (cmd.accept) begin
      col_nxt     = col_clamp;
      row_nxt     = row_clamp;
      scroll_nxt  = 1'b0;
      swp_row_nxt = '0;
      swp_col_nxt = '0;
    end

    mem_raddr = cmd.rd_swp ? {swp_row_r, swp_col_r}
                           : {RW'(in_read_row), CW'(in_read_column)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      scroll_r  <= 1'b0;
      swp_row_r <= '0;
      swp_col_r <= '0;
      cp_v_r    <= 1'b0;
      tab_end_r <= '0;
    end else begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      scroll_r  <= scroll_nxt;
      swp_row_r <= swp_row_nxt;
      swp_col_r <= swp_col_nxt;
      cp_v_r    <= cp_v_nxt;
      tab_end_r <= tab_end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r <= cp_addr_nxt;
    if (cmd.accept) begin
      cmd_r  <= cmd_t'(in_command);
      code_r <= in_char_code;
      rcol_r <= in_read_column;
      rrow_r <= in_read_row;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) rd_data_r <= cell_mem[mem_raddr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_cell_r    <= (cmd_r == CMD_READ && !outside) ? rd_data_r : '0;
      out_col_r     <= POS_COL_W'(col_nxt);
      out_row_r     <= POS_ROW_W'(row_nxt);
      out_scroll_r  <= scroll_r;
      out_outside_r <= (cmd_r == CMD_READ) && outside;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cell_char     = out_cell_r.ch;
  assign out_cell_fg       = out_cell_r.fg;
  assign out_cell_bg       = out_cell_r.bg;
  assign out_cursor_column = out_col_r;
  assign out_cursor_line   = out_row_r;
  assign out_did_scroll    = out_scroll_r;
  assign out_outside_grid  = out_outside_r;

  a_copy_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    cp_v_r |-> (cmd.op == OP_COPY || cmd.op == OP_BOTTOM))
    else $error("scroll copy write collides with another write");

  a_tab_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_TAB |-> col_r < tab_end_r)
    else $error("tab fill ran past its stop");

endmodule

`default_nettype wire

/* design/text_console_cell_engine.sv */
// Top level of the text console cell engine: controller plus datapath.
// Each item is accepted, then decoded; put char, CR, LF, BS, read and no-op then load
//   the result register. A tab first fills cells up to the next stop; a clear blanks all
//   rows*cols cells; a scroll copies rows up, then blanks the bottom row, or only blanks it
//   with a single row; a full result register adds its wait. One item in flight; the result
//   register holds while the next transfer comes in. The cell write port sets sweep lengths.
// Reset (rst_n low, synchronous): registers to defaults, cursor home, then a clearing
//   pass zeroes all MAX_ROWS * 2**clog2(MAX_COLUMNS) cells before in ready.
`default_nettype none

module text_console_cell_engine import tcce_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tcce_in_if.sink               in_if,
  tcce_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Command and status between the sequencer and the datapath
  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  // Sequencer: reset clearing pass, decode, tab fill, scroll copy, row blanking
  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (dp_sts),
    .cmd      (ctrl_cmd)
  );

  // Datapath: register file, cursor, cell memory and the result register
  tcce_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (ctrl_cmd),
    .sts               (dp_sts),
    .in_command        (in_if.command),
    .in_char_code      (in_if.char_code),
    .in_read_column    (in_if.read_column),
    .in_read_row       (in_if.read_row),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_if.ready),
    .out_valid         (out_if.valid),
    .out_cell_char     (out_if.cell_char),
    .out_cell_fg       (out_if.cell_fg),
    .out_cell_bg       (out_if.cell_bg),
    .out_cursor_column (out_if.cursor_column),
    .out_cursor_line   (out_if.cursor_line),
    .out_did_scroll    (out_if.did_scroll),
    .out_outside_grid  (out_if.outside_grid)
  );

endmodule

`default_nettype wire
